// ===== hdl/pac_pkg.sv =====
// shared types, constants and the base interval table for the autoscroll controller
// used by pac_div and pointer_autoscroll_controller; no dependencies

package pac_pkg;

    // stepped levels run from -LEVEL_COUNT to LEVEL_COUNT
    localparam int LEVEL_COUNT     = 9;
    localparam int MIN_INTERVAL_MS = 5;

    // port widths
    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 32;
    localparam int KIND_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 12;

    // serial divider sizing
    localparam int LVL_DIV_W = 15;  // base interval times 100 fits here
    localparam int DIV_W     = 27;  // interval span times jog position
    localparam int DVS_W     = 12;  // widest divisor (jog span)
    localparam int DIV_CNT_W = 5;   // holds DIV_W

    typedef enum logic [KIND_W-1:0] {
        KIND_MOTION = 2'd0,
        KIND_STEP   = 2'd1,
        KIND_JOG    = 2'd2,
        KIND_STOP   = 2'd3
    } kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED    = 2'd0,
        CFG_DEADZONE = 2'd1,
        CFG_SPAN     = 2'd2,
        CFG_INVERT   = 2'd3
    } cfg_idx_t;

    // request into the shared divider; dividend is left aligned
    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
        logic [DIV_W-1:0]     dividend;
        logic [DVS_W-1:0]     divisor;
    } div_req_t;

    // base step intervals in ms, slowest first, indexed by level magnitude minus one
    function automatic logic [15:0] base_interval(input logic [3:0] idx);
        logic [15:0] val;
        case (idx)
            4'd0:    val = 16'd200;
            4'd1:    val = 16'd150;
            4'd2:    val = 16'd110;
            4'd3:    val = 16'd80;
            4'd4:    val = 16'd60;
            4'd5:    val = 16'd45;
            4'd6:    val = 16'd33;
            4'd7:    val = 16'd24;
            4'd8:    val = 16'd16;
            4'd9:    val = 16'd12;
            4'd10:   val = 16'd10;
            4'd11:   val = 16'd8;
            4'd12:   val = 16'd6;
            4'd13:   val = 16'd5;
            4'd14:   val = 16'd4;
            default: val = 16'd0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/pac_div.sv =====
// restoring serial divider, one quotient bit per cycle, shared by all interval math
// depends on pac_pkg

module pac_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  pac_pkg::div_req_t              req,
    output logic                           done,
    output logic [pac_pkg::DIV_W-1:0]      quotient
);
    import pac_pkg::*;

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DIV_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     dvs_reg;

    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   trial_diff;
    logic             trial_ge;
    logic [DVS_W-1:0] rem_next;
    logic             last_step;

    // shift one dividend bit into the partial remainder
    assign trial      = {rem_reg, quo_reg[DIV_W-1]};
    assign trial_ge   = trial >= {1'b0, dvs_reg};
    assign trial_diff = trial - {1'b0, dvs_reg};
    assign rem_next   = trial_ge ? trial_diff[DVS_W-1:0] : trial[DVS_W-1:0];
    assign last_step  = busy_reg && (cnt_reg == DIV_CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= last_step;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                busy_reg <= !last_step;
                cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg <= '0;
            quo_reg <= req.dividend;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[DIV_W-2:0], trial_ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== hdl/pointer_autoscroll_controller.sv =====
// top level of the pointer autoscroll controller: sequencer, mode state, output register
// depends on pac_pkg and pac_div

// usage
// - input stream: one beat per pointer report or control event; tuser carries the kind
//   (motion, level step, jog toggle, stop), tdata the timestamp, step and report values
// - output stream: exactly one beat per input beat, in order, carrying the edited report
//   plus mode status; a control beat returns zero motion and zero wheel
// - cfg port: single-cycle writes of speed scale, deadzone, jog span and inversion;
//   write only while no beat is in flight
// - from accept to output valid: control beats pass decode and check; motion beats add
//   plan, then one level division when stepped or up to three divisions when jogging
// - throughput: one beat at a time; tready is high only while the sequencer is idle, so
//   the next beat goes in the cycle after the previous result is loaded
// - the divisions run in the single shared serial divider, one quotient bit each cycle
// - reset: level 0, jog off, deflection 0, last emit time 0, registers at their defaults,
//   no output beat pending
// - receiver stall: a finished result waits in the output register; a new beat is still
//   accepted and worked on, and its result holds in the final step until the register frees

module pointer_autoscroll_controller (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    // tdata from bit 0: now_ms[15:0], step_dir[20:16], move_x[28:21], move_y[36:29],
    // wheel_in[44:37], zero pad[47:45]
    input  logic [pac_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
    // tuser from bit 0: kind[1:0]
    input  logic [pac_pkg::KIND_W-1:0]           s_axis_tuser,
    // output stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    // tdata from bit 0: out_x[7:0], out_y[15:8], out_wheel[23:16], is_active[24],
    // cur_level[29:25], is_jogging[30], zero pad[31]
    output logic [pac_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
    // configuration writes
    input  logic                                 cfg_wr_en,
    input  logic [pac_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [pac_pkg::CFG_DATA_W-1:0]       cfg_data
);
    import pac_pkg::*;

    // one-hot sequencer
    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_DECODE   = 10'b00_0000_0010,
        S_PLAN     = 10'b00_0000_0100,
        S_DIV_LVL  = 10'b00_0000_1000,
        S_DIV_SLOW = 10'b00_0001_0000,
        S_DIV_FAST = 10'b00_0010_0000,
        S_MUL      = 10'b00_0100_0000,
        S_DIV_JOG  = 10'b00_1000_0000,
        S_CHECK    = 10'b01_0000_0000,
        S_UNUSED   = 10'b10_0000_0000
    } state_t;

    localparam logic signed [5:0]    LVL_MAX   = 6'(LEVEL_COUNT);
    localparam logic signed [5:0]    LVL_MIN   = -LVL_MAX;
    localparam logic [DIV_CNT_W-1:0] LVL_STEPS = DIV_CNT_W'(LVL_DIV_W);
    localparam logic [DIV_CNT_W-1:0] JOG_STEPS = DIV_CNT_W'(DIV_W);

    state_t state_reg, state_next;

    // configuration registers
    logic [8:0]  speed_reg;
    logic [7:0]  dz_reg;
    logic [11:0] span_reg;
    logic        invert_reg;

    // mode state
    logic signed [4:0]  level_reg;
    logic               jog_reg;
    logic signed [13:0] defl_reg;
    logic [15:0]        last_ms_reg;

    // beat being worked on
    kind_t              kind_reg;
    logic [15:0]        now_reg;
    logic signed [4:0]  step_reg;
    logic signed [7:0]  x_reg;
    logic signed [7:0]  y_reg;
    logic signed [7:0]  wheel_reg;

    // interval work registers
    logic        dir_en_reg;
    logic        dir_neg_reg;   // generated count is -1 before inversion
    logic [12:0] past_reg;      // deflection beyond the deadzone
    logic [15:0] interval_reg;
    logic [15:0] slow_reg;
    logic [14:0] diff_reg;      // slowest minus fastest interval

    // output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // divider hookup
    div_req_t         div_req;
    logic             div_done;
    logic [DIV_W-1:0] div_quotient;

    // level interval operands
    logic [4:0]           lvl_neg;
    logic [3:0]           lvl_mag;
    logic [3:0]           rom_mag;
    logic [15:0]          rom_base;
    logic [LVL_DIV_W-1:0] lvl_dividend;
    logic [DVS_W-1:0]     speed_div;
    logic [LVL_DIV_W-1:0] q_lvl;
    logic [15:0]          q_floor;
    logic [DIV_W-1:0]     jog_prod;

    // deflection update
    logic [12:0]        jog_lim;
    logic signed [14:0] lim_pos;
    logic signed [14:0] lim_neg;
    logic signed [14:0] defl_sum;
    logic [13:0]        defl_clamp;

    // jog direction and distance
    logic [13:0]        defl_neg;
    logic [12:0]        defl_abs;
    logic signed [13:0] past_s;
    logic               past_pos;
    logic               plan_dir_en;
    logic               plan_neg;

    // level step
    logic signed [4:0] lvl_base;
    logic signed [5:0] lvl_sum;
    logic [4:0]        lvl_clamp;

    // emit decision and wheel
    logic [15:0]       elapsed;
    logic              emit;
    logic              count_neg;
    logic signed [8:0] wheel_sum;
    logic [7:0]        wheel_sat;
    logic [7:0]        wheel_out;
    logic              active;
    logic              can_load;
    logic              span_reached;

    pac_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // level interval: base * 100 / speed, floored at the minimum interval
    assign lvl_neg      = -level_reg;
    assign lvl_mag      = level_reg[4] ? lvl_neg[3:0] : level_reg[3:0];
    assign rom_mag      = (state_reg == S_PLAN) ? (jog_reg ? 4'd1 : lvl_mag)
                                                : 4'(LEVEL_COUNT);
    assign rom_base     = base_interval(rom_mag - 4'd1);
    assign lvl_dividend = LVL_DIV_W'(rom_base * 16'd100);
    assign speed_div    = (speed_reg == '0) ? DVS_W'(1) : DVS_W'(speed_reg);
    assign q_lvl        = div_quotient[LVL_DIV_W-1:0];
    assign q_floor      = (q_lvl < LVL_DIV_W'(MIN_INTERVAL_MS)) ? 16'(MIN_INTERVAL_MS)
                                                                : {1'b0, q_lvl};
    assign jog_prod     = DIV_W'(diff_reg) * DIV_W'(past_reg[DVS_W-1:0]);
    assign span_reached = past_reg >= {1'b0, span_reg};

    // jog deflection winds with vertical motion, clamped to deadzone plus span
    assign jog_lim    = 13'(dz_reg) + 13'(span_reg);
    assign lim_pos    = $signed({2'b00, jog_lim});
    assign lim_neg    = -lim_pos;
    assign defl_sum   = $signed({defl_reg[13], defl_reg}) + $signed({{7{y_reg[7]}}, y_reg});
    assign defl_clamp = (defl_sum > lim_pos) ? lim_pos[13:0] :
                        (defl_sum < lim_neg) ? lim_neg[13:0] : defl_sum[13:0];

    // distance past the deadzone and scroll direction
    assign defl_neg    = -defl_reg;
    assign defl_abs    = defl_reg[13] ? defl_neg[12:0] : defl_reg[12:0];
    assign past_s      = $signed({1'b0, defl_abs}) - $signed({6'b00_0000, dz_reg});
    assign past_pos    = !past_s[13] && (past_s != '0);
    assign plan_dir_en = jog_reg ? past_pos : (level_reg != '0);
    // deflection down scrolls down, a positive level scrolls up
    assign plan_neg    = jog_reg ? (!defl_reg[13] && (defl_reg != '0)) : level_reg[4];

    // level step saturates; a step while jogging starts from level zero
    assign lvl_base  = jog_reg ? 5'sd0 : level_reg;
    assign lvl_sum   = $signed({lvl_base[4], lvl_base}) + $signed({step_reg[4], step_reg});
    assign lvl_clamp = (lvl_sum > LVL_MAX) ? LVL_MAX[4:0] :
                       (lvl_sum < LVL_MIN) ? LVL_MIN[4:0] : lvl_sum[4:0];

    // one wheel count once the interval has run out on the wrapping ms timer
    assign elapsed   = now_reg - last_ms_reg;
    assign emit      = dir_en_reg && (elapsed >= interval_reg);
    assign count_neg = dir_neg_reg ^ invert_reg;
    assign wheel_sum = $signed({wheel_reg[7], wheel_reg}) + (count_neg ? -9'sd1 : 9'sd1);
    assign wheel_sat = (wheel_sum > 9'sd127)  ? 8'sd127 :
                       (wheel_sum < -9'sd127) ? -8'sd127 : wheel_sum[7:0];
    assign wheel_out = emit ? wheel_sat : wheel_reg;
    assign active    = (level_reg != '0) || jog_reg;
    assign can_load  = !out_valid_reg || m_axis_tready;

    // sequencer and divider requests
    always_comb
    begin
        state_next       = state_reg;
        div_req.start    = 1'b0;
        div_req.steps    = LVL_STEPS;
        div_req.dividend = {lvl_dividend, {(DIV_W-LVL_DIV_W){1'b0}}};
        div_req.divisor  = speed_div;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                state_next = (kind_reg == KIND_MOTION) ? S_PLAN : S_CHECK;
            end
            S_PLAN:
            begin
                if (!plan_dir_en)
                    state_next = S_CHECK;
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = jog_reg ? S_DIV_SLOW : S_DIV_LVL;
                end
            end
            S_DIV_LVL:
            begin
                if (div_done)
                    state_next = S_CHECK;
            end
            S_DIV_SLOW:
            begin
                // fastest interval comes next
                if (div_done)
                begin
                    div_req.start = 1'b1;
                    state_next    = S_DIV_FAST;
                end
            end
            S_DIV_FAST:
            begin
                if (div_done)
                    state_next = span_reached ? S_CHECK : S_MUL;
            end
            S_MUL:
            begin
                div_req.start    = 1'b1;
                div_req.steps    = JOG_STEPS;
                div_req.dividend = jog_prod;
                div_req.divisor  = span_reg;
                state_next       = S_DIV_JOG;
            end
            S_DIV_JOG:
            begin
                if (div_done)
                    state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (can_load)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and mode state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            speed_reg     <= 9'd100;
            dz_reg        <= 8'd8;
            span_reg      <= 12'd400;
            invert_reg    <= 1'b0;
            level_reg     <= '0;
            jog_reg       <= 1'b0;
            defl_reg      <= '0;
            last_ms_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    CFG_SPEED:    speed_reg  <= cfg_data[8:0];
                    CFG_DEADZONE: dz_reg     <= cfg_data[7:0];
                    CFG_SPAN:     span_reg   <= cfg_data[11:0];
                    CFG_INVERT:   invert_reg <= cfg_data[0];
                    default:      invert_reg <= invert_reg;
                endcase
            end

            if (state_reg == S_DECODE)
            begin
                unique case (kind_reg)
                    KIND_MOTION:
                    begin
                        if (jog_reg)
                            defl_reg <= defl_clamp;
                    end
                    KIND_STEP:
                    begin
                        level_reg   <= lvl_clamp;
                        jog_reg     <= 1'b0;
                        if (jog_reg)
                            defl_reg <= '0;
                        last_ms_reg <= now_reg;
                    end
                    KIND_JOG:
                    begin
                        level_reg <= '0;
                        defl_reg  <= '0;
                        jog_reg   <= !jog_reg;
                        // entering jog restarts the interval
                        if (!jog_reg)
                            last_ms_reg <= now_reg;
                    end
                    KIND_STOP:
                    begin
                        level_reg <= '0;
                        jog_reg   <= 1'b0;
                        defl_reg  <= '0;
                    end
                    default:
                    begin
                        level_reg <= level_reg;
                    end
                endcase
            end

            if ((state_reg == S_CHECK) && can_load)
            begin
                out_valid_reg <= 1'b1;
                if (emit)
                    last_ms_reg <= now_reg;
            end
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // beat payload and interval working values
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && s_axis_tvalid)
        begin
            kind_reg  <= kind_t'(s_axis_tuser);
            now_reg   <= s_axis_tdata[15:0];
            step_reg  <= s_axis_tdata[20:16];
            x_reg     <= s_axis_tdata[28:21];
            y_reg     <= s_axis_tdata[36:29];
            wheel_reg <= s_axis_tdata[44:37];
        end

        if (state_reg == S_DECODE)
        begin
            dir_en_reg <= 1'b0;
            // cursor motion is swallowed while jogging; control beats report nothing
            if ((kind_reg != KIND_MOTION) || jog_reg)
            begin
                x_reg <= '0;
                y_reg <= '0;
            end
            if (kind_reg != KIND_MOTION)
                wheel_reg <= '0;
        end

        if (state_reg == S_PLAN)
        begin
            dir_en_reg  <= plan_dir_en;
            dir_neg_reg <= plan_neg;
            past_reg    <= past_s[12:0];
        end

        if ((state_reg == S_DIV_LVL) && div_done)
            interval_reg <= q_floor;

        if ((state_reg == S_DIV_SLOW) && div_done)
            slow_reg <= q_floor;

        if ((state_reg == S_DIV_FAST) && div_done)
        begin
            interval_reg <= q_floor;
            diff_reg     <= LVL_DIV_W'(slow_reg - q_floor);
        end

        // linear interpolation from the slowest toward the fastest interval
        if ((state_reg == S_DIV_JOG) && div_done)
            interval_reg <= slow_reg - {1'b0, q_lvl};

        if ((state_reg == S_CHECK) && can_load)
            out_data_reg <= {1'b0, jog_reg, level_reg, active, wheel_out, y_reg, x_reg};
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule
